FILE: sv/rwut_pkg.sv
// Shared types, field widths and register reset values for the RPROP weight-update table.
// Used by rprop_weight_update_table and the testbench; depends on nothing else.
`default_nettype none

package rwut_pkg;

    // Payload field widths
    localparam int CMD_W   = 1;
    localparam int IDX_W   = 7;
    localparam int VAL_W   = 40;
    localparam int SGN_W   = 2;
    localparam int STEP_W  = 32;
    localparam int FAC_W   = 18;
    localparam int FAC_FRAC = 16;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = ((IDX_W + VAL_W + SGN_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((IDX_W + VAL_W + STEP_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Table depth default
    localparam int NUM_ENTRIES_DEF = 128;

    // Register reset values
    localparam logic [FAC_W-1:0]  INC_FACTOR_RST   = FAC_W'(78643);
    localparam logic [FAC_W-1:0]  DEC_FACTOR_RST   = FAC_W'(32768);
    localparam logic [STEP_W-1:0] STEP_CEILING_RST = STEP_W'(838860800);
    localparam logic [STEP_W-1:0] STEP_FLOOR_RST   = STEP_W'(17);
    localparam logic [STEP_W-1:0] STEP_START_RST   = STEP_W'(167772);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_INC_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_START   = 3'd4;

    // Stored gradient sign codes (two's complement -1, 0, +1)
    localparam logic [SGN_W-1:0] SGN_ZERO = 2'b00;
    localparam logic [SGN_W-1:0] SGN_POS  = 2'b01;
    localparam logic [SGN_W-1:0] SGN_NEG  = 2'b11;

    // Saturation limits of a Q15.24 weight
    localparam logic [VAL_W-1:0] WEIGHT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] WEIGHT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 1'b0,
        CMD_UPDATE = 1'b1
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/rwut_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the per-entry state of the weight table; uses no package items.
`default_nettype none

module rwut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/rprop_weight_update_table.sv
// RPROP weight-update table: top level with the update pipeline and configuration registers.
// Depends on rwut_pkg and on rwut_ram for the entry store.
//
// The block keeps NUM_ENTRIES entries, each a Q15.24 weight, a Q8.24 step and the sign of
// the last gradient, in one RAM with a registered read. A beat with tuser 0 loads an entry;
// a beat with tuser 1 applies the sign of an accumulated gradient to it. Every input beat
// yields exactly one output beat, after stages 1, 2 and 3 and the output register. The
// block takes one beat per cycle as long as the output side does not stall and a beat
// addresses no entry held by one of the three items in flight; a beat that does waits
// until that item has written the entry back at the end of the pipeline. The entry index
// is taken modulo NUM_ENTRIES. Entries hold nothing defined until loaded, and must be
// loaded before they are updated. The configuration port is always ready; registers are
// to be written while no item is in flight.
`default_nettype none

module rprop_weight_update_table
    import rwut_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,   // entry_index[6:0], operand_value[46:7],
                                                    // start_sign[48:47], zero pad
    input  wire logic                  i_s_tuser,   // command[0]
    // Result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [M_TDATA_W-1:0]  o_m_tdata,   // entry_echo[6:0], weight_out[46:7],
                                                    // step_out[78:47], zero pad
    output logic                       o_m_tuser,   // saturated[0]
    // Configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W  = $clog2(NUM_ENTRIES);
    localparam int MOD_W   = ADDR_W + IDX_W + 1;
    localparam int ENTRY_W = SGN_W + STEP_W + VAL_W;
    localparam int PROD_W  = STEP_W + FAC_W;
    localparam int RND_W   = PROD_W + 1;
    localparam int SCL_W   = RND_W - FAC_FRAC;
    localparam int SUM_W   = VAL_W + 1;

    typedef enum logic [1:0] {
        K_LOAD,
        K_AGREE,
        K_DISAGREE,
        K_HOLD
    } t_kind;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_SUB,
        DIR_ADD
    } t_dir;

    // Item just accepted, waiting for its entry to come out of the RAM
    typedef struct packed {
        t_cmd                     cmd;
        logic [IDX_W-1:0]         raw_idx;
        logic [ADDR_W-1:0]        addr;
        logic signed [VAL_W-1:0]  operand;
        logic [SGN_W-1:0]         start_sgn;
    } t_s1;

    // Entry read, case decided, step times factor formed
    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         raw_idx;
        logic [ADDR_W-1:0]        addr;
        logic [SGN_W-1:0]         sgn;
        logic [VAL_W-1:0]         weight;
        logic [STEP_W-1:0]        step_old;
        logic [PROD_W-1:0]        prod;
    } t_s2;

    // New step known, weight move to be applied
    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         raw_idx;
        logic [ADDR_W-1:0]        addr;
        logic [SGN_W-1:0]         sgn;
        logic [VAL_W-1:0]         weight;
        logic [STEP_W-1:0]        step_new;
        logic [STEP_W-1:0]        mag;
        t_dir                     dir;
    } t_s3;

    // Configuration registers
    logic [FAC_W-1:0]  r_inc_factor;
    logic [FAC_W-1:0]  r_dec_factor;
    logic [STEP_W-1:0] r_step_ceiling;
    logic [STEP_W-1:0] r_step_floor;
    logic [STEP_W-1:0] r_step_start;

    // Pipeline registers
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_s1  r_s1;
    t_s2  r_s2;
    t_s3  r_s3;
    t_s1  n_s1;
    t_s2  n_s2;
    t_s3  n_s3;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                 r_out_sat;
    logic [M_TDATA_W-1:0] n_out_data;
    logic                 n_out_sat;

    // Handshake and hazard signals
    logic              s1_free, s2_free, s3_free;
    logic              s1_move, s2_move, out_load;
    logic              hazard, accept;
    logic [ADDR_W-1:0] in_addr;
    logic [MOD_W-1:0]  mod_val;

    // Entry store signals
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [VAL_W-1:0]   ram_weight;
    logic [STEP_W-1:0]  ram_step;
    logic [SGN_W-1:0]   ram_sgn;

    // Datapath signals
    logic [SGN_W-1:0]  grad_sgn;
    logic [SGN_W-1:0]  start_norm;
    t_kind             s1_kind;
    logic [FAC_W-1:0]  factor;
    logic [RND_W-1:0]  rnd_sum;
    logic [SCL_W-1:0]  scl_wide;
    logic [STEP_W-1:0] scaled;
    logic [SUM_W-1:0]  w_ext, mag_ext, w_sum;
    logic              w_sat;
    logic [VAL_W-1:0]  w_new;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_factor   <= INC_FACTOR_RST;
            r_dec_factor   <= DEC_FACTOR_RST;
            r_step_ceiling <= STEP_CEILING_RST;
            r_step_floor   <= STEP_FLOOR_RST;
            r_step_start   <= STEP_START_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INC_FACTOR:   r_inc_factor   <= i_cfg_data[FAC_W-1:0];
                CFG_DEC_FACTOR:   r_dec_factor   <= i_cfg_data[FAC_W-1:0];
                CFG_STEP_CEILING: r_step_ceiling <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_FLOOR:   r_step_floor   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_START:   r_step_start   <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode: entry index modulo the table depth by restoring reduction
    // ------------------------------------------------------------------
    always_comb begin
        mod_val = MOD_W'(i_s_tdata[IDX_W-1:0]);
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if (mod_val >= (MOD_W'(NUM_ENTRIES) << k)) begin
                mod_val = mod_val - (MOD_W'(NUM_ENTRIES) << k);
            end
        end
        in_addr = mod_val[ADDR_W-1:0];
    end

    always_comb begin
        n_s1.cmd       = t_cmd'(i_s_tuser);
        n_s1.raw_idx   = i_s_tdata[IDX_W-1:0];
        n_s1.addr      = in_addr;
        n_s1.operand   = i_s_tdata[IDX_W +: VAL_W];
        n_s1.start_sgn = i_s_tdata[IDX_W+VAL_W +: SGN_W];
    end

    // ------------------------------------------------------------------
    // Elastic pipeline control; an entry in flight blocks a new read of it
    // ------------------------------------------------------------------
    assign out_load = r_s3_valid && (!r_out_valid || i_m_tready);
    assign s3_free  = !r_s3_valid || out_load;
    assign s2_move  = r_s2_valid && s3_free;
    assign s2_free  = !r_s2_valid || s2_move;
    assign s1_move  = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s1_move;

    assign hazard = (r_s1_valid && (r_s1.addr == in_addr))
                 || (r_s2_valid && (r_s2.addr == in_addr))
                 || (r_s3_valid && (r_s3.addr == in_addr));

    assign o_s_tready = s1_free && !hazard;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_move) begin
                r_s3_valid <= 1'b1;
            end else if (out_load) begin
                r_s3_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_s2 <= n_s2;
        end
        if (s2_move) begin
            r_s3 <= n_s3;
        end
        if (out_load) begin
            r_out_data <= n_out_data;
            r_out_sat  <= n_out_sat;
        end
    end

    // ------------------------------------------------------------------
    // Entry store: read on accept, written back when an item leaves the last stage
    // ------------------------------------------------------------------
    rwut_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (out_load),
        .i_waddr (r_s3.addr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    assign ram_weight = ram_rdata[VAL_W-1:0];
    assign ram_step   = ram_rdata[VAL_W +: STEP_W];
    assign ram_sgn    = ram_rdata[VAL_W+STEP_W +: SGN_W];

    // ------------------------------------------------------------------
    // Stage 1: classify the sign pair and scale the stored step
    // ------------------------------------------------------------------
    always_comb begin
        if (r_s1.operand == '0) begin
            grad_sgn = SGN_ZERO;
        end else if (r_s1.operand[VAL_W-1]) begin
            grad_sgn = SGN_NEG;
        end else begin
            grad_sgn = SGN_POS;
        end

        // Any pattern with the top bit set counts as negative.
        if (r_s1.start_sgn == SGN_ZERO) begin
            start_norm = SGN_ZERO;
        end else if (r_s1.start_sgn[SGN_W-1]) begin
            start_norm = SGN_NEG;
        end else begin
            start_norm = SGN_POS;
        end

        if (r_s1.cmd == CMD_LOAD) begin
            s1_kind = K_LOAD;
        end else if ((ram_sgn == SGN_ZERO) || (grad_sgn == SGN_ZERO)) begin
            s1_kind = K_HOLD;
        end else if (ram_sgn[SGN_W-1] == grad_sgn[SGN_W-1]) begin
            s1_kind = K_AGREE;
        end else begin
            s1_kind = K_DISAGREE;
        end

        factor = (s1_kind == K_AGREE) ? r_inc_factor : r_dec_factor;

        n_s2.kind     = s1_kind;
        n_s2.raw_idx  = r_s1.raw_idx;
        n_s2.addr     = r_s1.addr;
        n_s2.sgn      = (s1_kind == K_LOAD) ? start_norm : grad_sgn;
        n_s2.weight   = (s1_kind == K_LOAD) ? r_s1.operand : ram_weight;
        n_s2.step_old = ram_step;
        n_s2.prod     = PROD_W'(ram_step) * PROD_W'(factor);
    end

    // ------------------------------------------------------------------
    // Stage 2: round the product, bound the new step, pick the weight move
    // ------------------------------------------------------------------
    always_comb begin
        rnd_sum  = {1'b0, r_s2.prod} + RND_W'(1 << (FAC_FRAC - 1));
        scl_wide = rnd_sum[RND_W-1:FAC_FRAC];
        scaled   = (|scl_wide[SCL_W-1:STEP_W]) ? '1 : scl_wide[STEP_W-1:0];

        n_s3.kind    = r_s2.kind;
        n_s3.raw_idx = r_s2.raw_idx;
        n_s3.addr    = r_s2.addr;
        n_s3.weight  = r_s2.weight;

        case (r_s2.kind)
            K_LOAD: begin
                n_s3.step_new = r_step_start;
                n_s3.mag      = '0;
                n_s3.dir      = DIR_NONE;
                n_s3.sgn      = r_s2.sgn;
            end
            K_AGREE: begin
                n_s3.step_new = (scaled > r_step_ceiling) ? r_step_ceiling : scaled;
                n_s3.mag      = n_s3.step_new;
                n_s3.dir      = (r_s2.sgn == SGN_POS) ? DIR_SUB : DIR_ADD;
                n_s3.sgn      = r_s2.sgn;
            end
            K_DISAGREE: begin
                // The weight gives back the old step and the sign history is cleared.
                n_s3.step_new = (scaled < r_step_floor) ? r_step_floor : scaled;
                n_s3.mag      = r_s2.step_old;
                n_s3.dir      = DIR_SUB;
                n_s3.sgn      = SGN_ZERO;
            end
            default: begin
                n_s3.step_new = r_s2.step_old;
                n_s3.mag      = r_s2.step_old;
                if (r_s2.sgn == SGN_ZERO) begin
                    n_s3.dir = DIR_NONE;
                end else if (r_s2.sgn == SGN_POS) begin
                    n_s3.dir = DIR_SUB;
                end else begin
                    n_s3.dir = DIR_ADD;
                end
                n_s3.sgn      = r_s2.sgn;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 3: move the weight with saturation, form the result and write-back
    // ------------------------------------------------------------------
    always_comb begin
        w_ext   = {r_s3.weight[VAL_W-1], r_s3.weight};
        mag_ext = SUM_W'(r_s3.mag);
        case (r_s3.dir)
            DIR_SUB: w_sum = w_ext - mag_ext;
            DIR_ADD: w_sum = w_ext + mag_ext;
            default: w_sum = w_ext;
        endcase

        w_sat = w_sum[SUM_W-1] ^ w_sum[SUM_W-2];
        if (w_sat) begin
            w_new = w_sum[SUM_W-1] ? WEIGHT_MIN : WEIGHT_MAX;
        end else begin
            w_new = w_sum[VAL_W-1:0];
        end

        ram_wdata  = {r_s3.sgn, r_s3.step_new, w_new};
        n_out_data = M_TDATA_W'({r_s3.step_new, w_new, r_s3.raw_idx});
        n_out_sat  = w_sat;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Items in flight never share an entry, or a read would miss a pending write-back.
    a_s1_s2_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid) |-> (r_s1.addr != r_s2.addr))
        else $error("stages 1 and 2 hold the same entry");

    a_s1_s3_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s3_valid) |-> (r_s1.addr != r_s3.addr))
        else $error("stages 1 and 3 hold the same entry");

    a_s2_s3_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s3_valid) |-> (r_s2.addr != r_s3.addr))
        else $error("stages 2 and 3 hold the same entry");

    // A result beat only appears after an item sat in the last stage.
    a_out_from_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_s3_valid))
        else $error("result beat without an item in the last stage");

    // A load never moves the weight it brings.
    a_load_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && (r_s3.kind == K_LOAD)) |-> (r_s3.dir == DIR_NONE))
        else $error("load item carries a weight move");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the RPROP weight-update table: stream driver, result monitor
// and a shadow copy of the entry table that predicts every result beat.
// Depends on rwut_pkg and on the rprop_weight_update_table RTL.
`default_nettype none

module testbench;
    import rwut_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH = NUM_ENTRIES_DEF;
    localparam int          PHASE_ITEMS = 219;
    localparam int          PHASES      = 8;
    localparam int unsigned FAC_MAX     = (1 << FAC_W) - 1;
    localparam logic [SGN_W-1:0] SGN_MINUS_TWO = 2'b10;
    localparam longint      W_HI = 64'sd549755813887;
    localparam longint      W_LO = -64'sd549755813888;

    typedef struct {
        t_cmd               cmd;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   operand;
        logic [SGN_W-1:0]   start_sgn;
    } t_table_cmd;

    typedef struct {
        logic [IDX_W-1:0]   echo;
        logic [VAL_W-1:0]   weight;
        logic [STEP_W-1:0]  step;
        logic               sat;
    } t_weight_result;

    // DUT connections; every input has a known value from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    rprop_weight_update_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow configuration, starting from the register reset values.
    logic [FAC_W-1:0]  cur_inc     = INC_FACTOR_RST;
    logic [FAC_W-1:0]  cur_dec     = DEC_FACTOR_RST;
    logic [STEP_W-1:0] cur_ceiling = STEP_CEILING_RST;
    logic [STEP_W-1:0] cur_floor   = STEP_FLOOR_RST;
    logic [STEP_W-1:0] cur_start   = STEP_START_RST;

    // Shadow entry table.
    longint            weight_shadow [TABLE_DEPTH];
    logic [STEP_W-1:0] step_shadow   [TABLE_DEPTH];
    int                sign_shadow   [TABLE_DEPTH];
    bit                loaded        [TABLE_DEPTH];

    t_table_cmd     command_backlog [$];
    t_weight_result predicted_updates [$];
    int unsigned    mismatches = 0;
    logic           beat_taken = 1'b0;

    // Clock: 4 ns period.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Step times a Q2.16 factor, rounded half up and saturated to 32 bits.
    function automatic logic [STEP_W-1:0] scaled_step(input logic [STEP_W-1:0] s,
                                                      input logic [FAC_W-1:0] f);
        logic [63:0] p;
        p = (64'(s) * 64'(f) + 64'd32768) >> FAC_FRAC;
        return (p > 64'hFFFF_FFFF) ? '1 : p[STEP_W-1:0];
    endfunction

    // Apply one accepted command beat to the shadow table and return the result it yields.
    function automatic t_weight_result predict_entry_update(input logic [S_TDATA_W-1:0] data,
                                                            input logic cmd_bit);
        t_weight_result    r;
        int unsigned       e;
        logic signed [VAL_W-1:0] operand;
        logic [SGN_W-1:0]  ss;
        logic [STEP_W-1:0] old_step;
        logic [STEP_W-1:0] new_step;
        longint            nw;
        int                g;
        int                prev;
        int                new_sgn;
        r.echo  = data[IDX_W-1:0];
        operand = data[IDX_W +: VAL_W];
        ss      = data[IDX_W+VAL_W +: SGN_W];
        e       = r.echo % TABLE_DEPTH;
        r.sat   = 1'b0;
        if (t_cmd'(cmd_bit) == CMD_LOAD) begin
            weight_shadow[e] = longint'(operand);
            step_shadow[e]   = cur_start;
            // The pattern for minus two counts as negative.
            sign_shadow[e]   = (ss == SGN_ZERO) ? 0 : (ss[1] ? -1 : 1);
            r.weight = operand;
            r.step   = cur_start;
        end else begin
            g        = (operand > 0) ? 1 : ((operand < 0) ? -1 : 0);
            prev     = sign_shadow[e];
            old_step = step_shadow[e];
            nw       = weight_shadow[e];
            if (prev * g > 0) begin
                // Same direction twice: accelerate, capped at the ceiling.
                new_step = scaled_step(old_step, cur_inc);
                if (new_step > cur_ceiling)
                    new_step = cur_ceiling;
                nw      = nw - longint'(g) * longint'({32'd0, new_step});
                new_sgn = g;
            end else if (prev * g < 0) begin
                // Sign flip: back off by the old step and forget the sign.
                new_step = scaled_step(old_step, cur_dec);
                if (new_step < cur_floor)
                    new_step = cur_floor;
                nw      = nw - longint'({32'd0, old_step});
                new_sgn = 0;
            end else begin
                new_step = old_step;
                nw       = nw - longint'(g) * longint'({32'd0, new_step});
                new_sgn  = g;
            end
            if (nw > W_HI) begin
                nw    = W_HI;
                r.sat = 1'b1;
            end
            if (nw < W_LO) begin
                nw    = W_LO;
                r.sat = 1'b1;
            end
            weight_shadow[e] = nw;
            step_shadow[e]   = new_step;
            sign_shadow[e]   = new_sgn;
            r.weight = nw[VAL_W-1:0];
            r.step   = new_step;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [IDX_W-1:0] echo,
                               input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch entry %0d %s: expected %h, got %h", echo, name, want, got);
        end
    endtask

    // Monitor: record accepted command beats and check result beats, both at the rising edge.
    always @(posedge i_clk) begin : result_monitor
        t_weight_result want;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                if (predicted_updates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat for entry %0d with nothing pending",
                                 o_m_tdata[IDX_W-1:0]);
                end else begin
                    want = predicted_updates.pop_front();
                    check_field("entry_echo", want.echo, 64'(want.echo),
                                64'(o_m_tdata[IDX_W-1:0]));
                    check_field("weight_out", want.echo, 64'(want.weight),
                                64'(o_m_tdata[IDX_W +: VAL_W]));
                    check_field("step_out", want.echo, 64'(want.step),
                                64'(o_m_tdata[IDX_W+VAL_W +: STEP_W]));
                    check_field("saturated", want.echo, 64'(want.sat), 64'(o_m_tuser));
                end
            end
            if (i_s_tvalid && o_s_tready)
                predicted_updates = {predicted_updates,
                                     predict_entry_update(i_s_tdata, i_s_tuser)};
        end
    end

    // Driver: sends the backlog in bursts separated by random gaps.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin : command_driver
        t_table_cmd c;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || beat_taken) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (command_backlog.size() != 0) begin
                c = command_backlog.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= c.cmd;
                i_s_tdata  <= S_TDATA_W'({c.start_sgn, c.operand, c.idx});
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: back-pressure in randomly chosen modes, each held for a random time.
    int unsigned sink_mode = 0;
    int unsigned mode_left = 0;

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            sink_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(30, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (sink_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= $urandom_range(0, 1);
            2:       i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Register write; the shadow copy follows at the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_INC_FACTOR:   cur_inc     = val[FAC_W-1:0];
            CFG_DEC_FACTOR:   cur_dec     = val[FAC_W-1:0];
            CFG_STEP_CEILING: cur_ceiling = val;
            CFG_STEP_FLOOR:   cur_floor   = val;
            CFG_STEP_START:   cur_start   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_item(input t_cmd c, input int unsigned e,
                              input logic [VAL_W-1:0] v, input logic [SGN_W-1:0] s);
        t_table_cmd it;
        it.cmd       = c;
        it.idx       = IDX_W'(e);
        it.operand   = v;
        it.start_sgn = s;
        if (c == CMD_LOAD)
            loaded[e] = 1'b1;
        command_backlog = {command_backlog, it};
    endtask

    // Operand mix: full range, near either limit, zero, tiny and moderate values.
    function automatic logic [VAL_W-1:0] rand_operand();
        logic [VAL_W-1:0] v;
        v[31:0]      = $urandom();
        v[VAL_W-1:32] = 8'($urandom());
        case ($urandom_range(0, 9))
            0:       ;
            1:       v = WEIGHT_MAX - VAL_W'($urandom_range(0, 1 << 24));
            2:       v = WEIGHT_MIN + VAL_W'($urandom_range(0, 1 << 24));
            3:       v = '0;
            4:       v = {{(VAL_W-3){v[2]}}, v[2:0]};
            default: v = {{(VAL_W-32){v[31]}}, v[31:0]};
        endcase
        return v;
    endfunction

    // Directed opening: agreeing, flipping and zero signs, saturation at both limits, start signs.
    task automatic queue_directed();
        queue_item(CMD_LOAD,   0,   '0,            SGN_POS);
        queue_item(CMD_UPDATE, 0,   WEIGHT_MAX,    SGN_ZERO);
        queue_item(CMD_UPDATE, 0,   VAL_W'(1),     SGN_ZERO);
        queue_item(CMD_UPDATE, 0,   WEIGHT_MIN,    SGN_ZERO);
        queue_item(CMD_UPDATE, 0,   '1,            SGN_NEG);
        queue_item(CMD_UPDATE, 0,   '0,            SGN_ZERO);
        queue_item(CMD_LOAD,   127, WEIGHT_MAX,    SGN_NEG);
        queue_item(CMD_UPDATE, 127, -VAL_W'(5),    SGN_ZERO);
        queue_item(CMD_LOAD,   1,   WEIGHT_MIN,    SGN_MINUS_TWO);
        queue_item(CMD_UPDATE, 1,   VAL_W'(7),     SGN_ZERO);
        queue_item(CMD_LOAD,   2,   WEIGHT_MIN,    SGN_ZERO);
        queue_item(CMD_UPDATE, 2,   VAL_W'(3),     SGN_ZERO);
        queue_item(CMD_LOAD,   85,  rand_operand(), SGN_NEG);
        queue_item(CMD_LOAD,   42,  rand_operand(), SGN_POS);
        queue_item(CMD_UPDATE, 85,  -VAL_W'(9),    SGN_ZERO);
        queue_item(CMD_UPDATE, 42,  VAL_W'(9),     SGN_ZERO);
        // Same entry back to back.
        queue_item(CMD_LOAD,   64,  '1,            SGN_POS);
        queue_item(CMD_UPDATE, 64,  VAL_W'(100),   SGN_ZERO);
        queue_item(CMD_UPDATE, 64,  VAL_W'(200),   SGN_ZERO);
        queue_item(CMD_UPDATE, 64,  -VAL_W'(1),    SGN_ZERO);
        queue_item(CMD_UPDATE, 64,  -VAL_W'(1),    SGN_ZERO);
    endtask

    // Random traffic: mostly updates of loaded entries, with a small hot set for reuse.
    task automatic queue_random(input int unsigned count);
        int unsigned hot [4];
        int unsigned e;
        int unsigned k;
        for (k = 0; k < count; k++) begin
            if (k % 48 == 0)
                foreach (hot[j]) hot[j] = $urandom_range(0, TABLE_DEPTH - 1);
            e = ($urandom_range(0, 9) < 4) ? hot[$urandom_range(0, 3)]
                                           : $urandom_range(0, TABLE_DEPTH - 1);
            if (!loaded[e] || $urandom_range(0, 4) == 0)
                queue_item(CMD_LOAD, e, rand_operand(), SGN_W'($urandom_range(0, 3)));
            else
                queue_item(CMD_UPDATE, e, rand_operand(), SGN_W'($urandom_range(0, 3)));
        end
    endtask

    // Register settings per phase: all ones, all zeros, reset values, then random.
    task automatic configure_phase(input int unsigned p);
        logic [CFG_DATA_W-1:0] inc, dec, ceil, flr, st;
        case (p)
            0: begin
                inc = FAC_MAX; dec = FAC_MAX; ceil = '1; flr = '1; st = '1;
            end
            1: begin
                inc = '0; dec = '0; ceil = '0; flr = '0; st = '0;
            end
            2: begin
                inc = INC_FACTOR_RST; dec = DEC_FACTOR_RST; ceil = STEP_CEILING_RST;
                flr = STEP_FLOOR_RST; st = STEP_START_RST;
            end
            default: begin
                inc  = $urandom_range(0, 1) ? $urandom_range(65536, 131072)
                                            : $urandom_range(0, FAC_MAX);
                dec  = $urandom_range(0, 1) ? $urandom_range(8192, 65536)
                                            : $urandom_range(0, FAC_MAX);
                ceil = $urandom_range(0, 1) ? $urandom_range(1 << 16, 1 << 26) : $urandom();
                flr  = $urandom_range(0, 1 << 12);
                st   = $urandom_range(1 << 12, 1 << 24);
            end
        endcase
        write_reg(CFG_INC_FACTOR,   inc);
        write_reg(CFG_DEC_FACTOR,   dec);
        write_reg(CFG_STEP_CEILING, ceil);
        write_reg(CFG_STEP_FLOOR,   flr);
        write_reg(CFG_STEP_START,   st);
    endtask

    // Wait until every command is sent and every result is back, then let the pipe drain.
    task automatic settle();
        int unsigned waited;
        waited = 0;
        while ((command_backlog.size() != 0 || i_s_tvalid || predicted_updates.size() != 0)
               && waited < 200000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned p;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        queue_directed();
        settle();
        for (p = 0; p < PHASES; p++) begin
            configure_phase(p);
            queue_random(PHASE_ITEMS);
            settle();
        end
        mismatches += predicted_updates.size();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
